### hw/rtl/aperture_interpolation_table_defines.svh
// assertion macros for the aperture interpolation table
`ifndef APERTURE_INTERPOLATION_TABLE_DEFINES_SVH
`define APERTURE_INTERPOLATION_TABLE_DEFINES_SVH

`ifndef SYNTH
`define AIT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AIT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AIT_ASSERT_SAME(label, ante, cons)
`define AIT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hw/rtl/aitab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aitab_pkg
// types and constants of the aperture interpolation table
// ----------------------------------------------------------------------------
package aitab_pkg;

  localparam int POS_BITS    = 16;
  localparam int VAL_BITS    = 24;
  localparam int PROD_BITS   = POS_BITS + VAL_BITS;
  localparam int TABLE_DEPTH = 256;

  localparam logic [POS_BITS:0]   ONE_POS = {1'b1, {POS_BITS{1'b0}}};
  localparam logic [POS_BITS-1:0] DEF_ONE_POS =
    POS_BITS'(((64'd1 << POS_BITS) * 64'd99999) / 64'd100000);
  localparam logic [POS_BITS-1:0] CLAMP_POS =
    POS_BITS'(((64'd1 << POS_BITS) * 64'd9999) / 64'd10000);

  typedef enum logic [1:0] {
    OP_DEFINE = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ORDER = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef logic [3:0][VAL_BITS-1:0] vals_t;

  typedef struct packed {
    logic [POS_BITS-1:0] pos;
    vals_t               vals;
  } entry_t;

  typedef struct packed {
    logic [1:0]          op;
    logic [POS_BITS:0]   position;
    logic [VAL_BITS-1:0] value_one;
    logic [VAL_BITS-1:0] value_two;
    logic [VAL_BITS-1:0] value_three;
    logic [VAL_BITS-1:0] value_four;
  } in_item_t;

  typedef struct packed {
    logic [VAL_BITS-1:0] out_one;
    logic [VAL_BITS-1:0] out_two;
    logic [VAL_BITS-1:0] out_three;
    logic [VAL_BITS-1:0] out_four;
    logic [1:0]          status;
  } out_item_t;

endpackage

### hw/rtl/aitab_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aitab_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module aitab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/aperture_interpolation_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aperture_interpolation_table
// piecewise-linear table of four aperture values over one unit interval
// ----------------------------------------------------------------------------
//  channel  dir  ports                      item
//  input    in   in_valid in_ready in_data  op, position, four values
//  result   out  out_valid out_ready out_data  four values, status
//
//  define, clear and no-op pass from accept through S_OUT to the output register
//  lookup is a scan reading one entry a cycle from the ram, then, where it
//  interpolates, one shared multiplier and one bit-serial divider per value,
//  for the four values one after another
//  synchronous reset empties the table; the ram needs no clearing
//  a stalled result waits in the output register, input accepted only when idle
// ----------------------------------------------------------------------------
`include "aperture_interpolation_table_defines.svh"

module aperture_interpolation_table
  import aitab_pkg::*;
#(
  parameter int TABLE_DEPTH = aitab_pkg::TABLE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int BW = $clog2(PROD_BITS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [POS_BITS-1:0]   last_pos_r, last_pos_nxt;
  logic [POS_BITS-1:0]   p_r, p_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [POS_BITS-1:0]   e1_pos_r, e1_pos_nxt, e2_pos_r, e2_pos_nxt;
  logic [POS_BITS-1:0]   cur_pos_r, cur_pos_nxt;
  vals_t                 e1_r, e1_nxt, e2_r, e2_nxt, cur_r, cur_nxt, v0_r, v0_nxt;
  vals_t                 res_r, res_nxt;
  logic [1:0]            status_r, status_nxt;
  logic [1:0]            ch_r, ch_nxt;
  logic [PROD_BITS-1:0]  quo_r, quo_nxt;
  logic [POS_BITS-1:0]   rem_r, rem_nxt;
  logic [BW-1:0]         bit_r, bit_nxt;
  logic                  neg_r, neg_nxt;
  logic [VAL_BITS-1:0]   base_r, base_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  entry_t                wdata, rd;
  logic [POS_BITS-1:0]   def_pos, fold_pos, num, den;
  logic [POS_BITS:0]     trial;
  logic [VAL_BITS-1:0]   a0, a1, mag, q;
  logic                  qb;

  aitab_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd)
  );

  function automatic vals_t vmin(vals_t a, vals_t b);
    vals_t m;
    for (int c = 0; c < 4; c++) begin
      m[c] = (a[c] < b[c]) ? a[c] : b[c];
    end
    return m;
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign def_pos  = (in_data.position == ONE_POS) ? DEF_ONE_POS
                                                  : in_data.position[POS_BITS-1:0];
  assign fold_pos = (in_data.position == ONE_POS) ? CLAMP_POS
                  : ((in_data.position[POS_BITS-1:0] > CLAMP_POS) ? CLAMP_POS
                  : in_data.position[POS_BITS-1:0]);
  assign num = p_r - e1_pos_r;
  assign den = cur_pos_r - e1_pos_r;
  assign a0  = e1_r[ch_r];
  assign a1  = cur_r[ch_r];
  assign mag = (a1 < a0) ? (a0 - a1) : (a1 - a0);
  assign trial = {rem_r, quo_r[PROD_BITS-1]};
  assign qb    = (trial >= {1'b0, den});
  assign q     = VAL_BITS'({quo_r[PROD_BITS-2:0], qb});

  assign we         = (state_r == S_IDLE) && in_valid && (in_data.op == OP_DEFINE) &&
                      !(count_r != '0 && def_pos < last_pos_r) &&
                      (count_r != CW'(TABLE_DEPTH));
  assign waddr      = count_r[AW-1:0];
  assign wdata.pos  = def_pos;
  assign wdata.vals = {in_data.value_four, in_data.value_three,
                       in_data.value_two, in_data.value_one};
  assign raddr      = (state_r == S_SCAN) ? AW'(idx_r + CW'(1)) : '0;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    last_pos_nxt  = last_pos_r;
    p_nxt         = p_r;
    idx_nxt       = idx_r;
    e1_pos_nxt    = e1_pos_r;
    e2_pos_nxt    = e2_pos_r;
    cur_pos_nxt   = cur_pos_r;
    e1_nxt        = e1_r;
    e2_nxt        = e2_r;
    cur_nxt       = cur_r;
    v0_nxt        = v0_r;
    res_nxt       = res_r;
    status_nxt    = status_r;
    ch_nxt        = ch_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    neg_nxt       = neg_r;
    base_nxt      = base_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt    = '0;
          status_nxt = ST_OK;
          state_nxt  = S_OUT;
          case (in_data.op)
            OP_DEFINE: begin
              if (count_r != '0 && def_pos < last_pos_r) begin
                status_nxt = ST_ORDER;
              end else if (count_r == CW'(TABLE_DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                count_nxt    = count_r + CW'(1);
                last_pos_nxt = def_pos;
              end
            end
            OP_LOOKUP: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                p_nxt     = fold_pos;
                idx_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            OP_CLEAR: count_nxt = '0;
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (idx_r == '0) begin
          v0_nxt = rd.vals;
        end
        if (rd.pos > p_r) begin
          if (idx_r >= CW'(2) && e2_pos_r == p_r && e1_pos_r == p_r) begin
            res_nxt   = vmin(e2_r, e1_r);
            state_nxt = S_OUT;
          end else if (idx_r == '0) begin
            res_nxt   = rd.vals;
            state_nxt = S_OUT;
          end else if (p_r == '0) begin
            res_nxt   = v0_r;
            state_nxt = S_OUT;
          end else begin
            cur_nxt     = rd.vals;
            cur_pos_nxt = rd.pos;
            ch_nxt      = '0;
            state_nxt   = S_MUL;
          end
        end else begin
          e2_nxt     = e1_r;
          e2_pos_nxt = e1_pos_r;
          e1_nxt     = rd.vals;
          e1_pos_nxt = rd.pos;
          if (idx_r == count_r - CW'(1)) begin
            state_nxt = S_OUT;
            if (idx_r != '0 && e1_pos_r == p_r && rd.pos == p_r) begin
              res_nxt = vmin(e1_r, rd.vals);
            end else if (p_r == '0 && idx_r != '0) begin
              res_nxt = v0_r;
            end else begin
              res_nxt = rd.vals;
            end
          end else begin
            idx_nxt = idx_r + CW'(1);
          end
        end
      end
      S_MUL: begin
        neg_nxt  = (a1 < a0);
        base_nxt = a0;
        quo_nxt  = PROD_BITS'(mag) * PROD_BITS'(num);
        rem_nxt  = '0;
        bit_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = qb ? POS_BITS'(trial - {1'b0, den}) : POS_BITS'(trial);
        quo_nxt = {quo_r[PROD_BITS-2:0], qb};
        bit_nxt = bit_r + BW'(1);
        if (bit_r == BW'(PROD_BITS - 1)) begin
          res_nxt[ch_r] = neg_r ? (base_r - q) : (base_r + q);
          if (ch_r == 2'd3) begin
            state_nxt = S_OUT;
          end else begin
            ch_nxt    = ch_r + 2'd1;
            state_nxt = S_MUL;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.out_one   = res_r[0];
          out_data_nxt.out_two   = res_r[1];
          out_data_nxt.out_three = res_r[2];
          out_data_nxt.out_four  = res_r[3];
          out_data_nxt.status    = status_r;
          state_nxt              = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_pos_r <= last_pos_nxt;
    p_r        <= p_nxt;
    idx_r      <= idx_nxt;
    e1_pos_r   <= e1_pos_nxt;
    e2_pos_r   <= e2_pos_nxt;
    cur_pos_r  <= cur_pos_nxt;
    e1_r       <= e1_nxt;
    e2_r       <= e2_nxt;
    cur_r      <= cur_nxt;
    v0_r       <= v0_nxt;
    res_r      <= res_nxt;
    status_r   <= status_nxt;
    ch_r       <= ch_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    bit_r      <= bit_nxt;
    neg_r      <= neg_nxt;
    base_r     <= base_nxt;
    out_data_r <= out_data_nxt;
  end

  `AIT_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state_r != S_IDLE)
  `AIT_ASSERT_SAME(a_scan_nonempty, state_r == S_SCAN, count_r != '0)
  `AIT_ASSERT_SAME(a_count_range, 1'b1, count_r <= CW'(TABLE_DEPTH))
  `AIT_ASSERT_SAME(a_empty_zero, out_valid && out_data.status == ST_EMPTY,
                   out_data.out_one == '0 && out_data.out_four == '0)
  `AIT_ASSERT_SAME(a_div_den, state_r == S_DIV, den != '0)

endmodule
